// ===== hw/rtl/ufd_pkg.sv =====
// ufd_pkg: shared types and constants for the UBX frame deframer.
// Used by ufd_parser and ubx_frame_deframer_core; no dependencies.
`timescale 1ns / 1ps

package ufd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int POS_W    = LEN_W + 1;
    localparam int CFG_IDX_W = 1;

    // Sync and foreign start bytes
    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;
    localparam logic [BYTE_W-1:0] START_NMEA  = 8'h24;
    localparam logic [BYTE_W-1:0] START_RTCM  = 8'hD3;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_SYNC1   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC2   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CLASS   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ID      = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(6);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CLASS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID    = 1'b1;

    localparam logic [BYTE_W-1:0] EXPECTED_CLASS_RST = 8'd6;
    localparam logic [BYTE_W-1:0] EXPECTED_ID_RST    = 8'd0;

    typedef enum logic [1:0] {
        START_NONE     = 2'd0,
        START_SEEN_NMEA = 2'd1,
        START_SEEN_RTCM = 2'd2,
        START_BAD_SYNC = 2'd3
    } start_status_t;

    // One result item
    typedef struct packed {
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [LEN_W-1:0]    payload_index;
        logic                frame_done;
        logic                checksum_ok;
        logic                class_id_match;
        logic [BYTE_W-1:0]   frame_class;
        logic [BYTE_W-1:0]   frame_id;
        logic [LEN_W-1:0]    frame_length;
        start_status_t       start_status;
    } ufd_result_t;

endpackage

// ===== hw/rtl/ufd_parser.sv =====
// ufd_parser: frame position tracking, Fletcher-8 sum and per-byte result.
// Depends on ufd_pkg.
`timescale 1ns / 1ps

module ufd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [ufd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [ufd_pkg::BYTE_W-1:0]  expected_class,
    input  logic [ufd_pkg::BYTE_W-1:0]  expected_id,
    output ufd_pkg::ufd_result_t        result
);
    import ufd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] class_reg, class_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;
    logic [BYTE_W-1:0] ck_a_reg, ck_a_next;

    logic [BYTE_W-1:0] sum_a_add;
    logic [BYTE_W-1:0] sum_b_add;
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  len_ext;

    // Fletcher step and payload offset
    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign offset    = pos_reg - POS_PAYLOAD;
    assign len_ext   = {1'b0, len_reg};

    // Next state and result for the byte at the input
    always_comb
    begin
        pos_next   = pos_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        ck_a_next  = ck_a_reg;

        result               = '0;
        result.start_status  = START_NONE;

        case (pos_reg)
            POS_SYNC1:
            begin
                if (rx_byte == SYNC_FIRST)
                    pos_next = POS_SYNC2;
                else if (rx_byte == START_NMEA)
                    result.start_status = START_SEEN_NMEA;
                else if (rx_byte == START_RTCM)
                    result.start_status = START_SEEN_RTCM;
            end
            POS_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    pos_next   = POS_CLASS;
                    class_next = '0;
                    id_next    = '0;
                    len_next   = '0;
                    sum_a_next = '0;
                    sum_b_next = '0;
                end
                else
                begin
                    pos_next            = POS_SYNC1;
                    result.start_status = START_BAD_SYNC;
                end
            end
            POS_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                pos_next   = POS_ID;
            end
            POS_ID:
            begin
                id_next    = rx_byte;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                pos_next   = POS_LEN_LO;
            end
            POS_LEN_LO:
            begin
                len_next   = LEN_W'(rx_byte);
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                pos_next   = POS_LEN_HI;
            end
            POS_LEN_HI:
            begin
                len_next   = {rx_byte, len_reg[BYTE_W-1:0]};
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                pos_next   = POS_PAYLOAD;
            end
            default:
            begin
                if (offset < len_ext)
                begin
                    // payload byte
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    result.payload_index = offset[LEN_W-1:0];
                    sum_a_next           = sum_a_add;
                    sum_b_next           = sum_b_add;
                    pos_next             = pos_reg + POS_W'(1);
                end
                else if (offset == len_ext)
                begin
                    // CK_A
                    ck_a_next = rx_byte;
                    pos_next  = pos_reg + POS_W'(1);
                end
                else
                begin
                    // CK_B closes the frame
                    result.frame_done     = 1'b1;
                    result.checksum_ok    = (ck_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
                    result.class_id_match = (class_reg == expected_class)
                                            && (id_reg == expected_id);
                    pos_next              = POS_SYNC1;
                end
            end
        endcase

        result.frame_class  = class_next;
        result.frame_id     = id_next;
        result.frame_length = len_next;
    end

    // Parser state, advanced once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_SYNC1;
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            ck_a_reg  <= '0;
        end
        else if (fire)
        begin
            pos_reg   <= pos_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            ck_a_reg  <= ck_a_next;
        end
    end

endmodule

// ===== hw/rtl/ubx_frame_deframer_core.sv =====
// ubx_frame_deframer_core: top level of the UBX frame deframer.
// Depends on ufd_pkg and ufd_parser.
`timescale 1ns / 1ps

// Takes one received byte per input transfer and produces exactly one result
// per byte: payload bytes with their index, frame-end flags (checksum and
// class/id match) on CK_B, and a start status for foreign or bad sync bytes.
// A byte is captured in an input register, parsed by short logic and lands in
// an output register. One byte is taken every cycle while the output side
// keeps up; the single parser update per byte sets that rate. Write
// expected_class (index 0) and expected_id (index 1) only while no byte is
// in flight.
module ubx_frame_deframer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // byte input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ufd_pkg::BYTE_W-1:0]    rx_byte,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          payload_valid,
    output logic [ufd_pkg::BYTE_W-1:0]    payload_byte,
    output logic [ufd_pkg::LEN_W-1:0]     payload_index,
    output logic                          frame_done,
    output logic                          checksum_ok,
    output logic                          class_id_match,
    output logic [ufd_pkg::BYTE_W-1:0]    frame_class,
    output logic [ufd_pkg::BYTE_W-1:0]    frame_id,
    output logic [ufd_pkg::LEN_W-1:0]     frame_length,
    output logic [1:0]                    start_status,
    // configuration
    input  logic                          cfg_we,
    input  logic [ufd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ufd_pkg::BYTE_W-1:0]    cfg_data
);
    import ufd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_valid_reg;
    ufd_result_t       out_reg;
    ufd_result_t       result;
    logic              adv;
    logic [BYTE_W-1:0] exp_class_reg;
    logic [BYTE_W-1:0] exp_id_reg;

    // Pipeline handshake
    assign adv      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_class_reg <= EXPECTED_CLASS_RST;
            exp_id_reg    <= EXPECTED_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_CLASS: exp_class_reg <= cfg_data;
                CFG_EXPECTED_ID:    exp_id_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= rx_byte;
        if (adv)
            out_reg <= result;
    end

    ufd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (adv),
        .rx_byte        (byte_reg),
        .expected_class (exp_class_reg),
        .expected_id    (exp_id_reg),
        .result         (result)
    );

    // Output ports
    assign out_valid      = out_valid_reg;
    assign payload_valid  = out_reg.payload_valid;
    assign payload_byte   = out_reg.payload_byte;
    assign payload_index  = out_reg.payload_index;
    assign frame_done     = out_reg.frame_done;
    assign checksum_ok    = out_reg.checksum_ok;
    assign class_id_match = out_reg.class_id_match;
    assign frame_class    = out_reg.frame_class;
    assign frame_id       = out_reg.frame_id;
    assign frame_length   = out_reg.frame_length;
    assign start_status   = out_reg.start_status;

    // Checks
    a_done_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.frame_done && out_reg.payload_valid))
        else $error("frame end and payload byte in one result");

    a_done_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_done) |-> (out_reg.start_status == START_NONE))
        else $error("start status reported on frame end");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.payload_valid)
        |-> (out_reg.payload_index < out_reg.frame_length))
        else $error("payload index beyond declared length");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(byte_reg)))
        else $error("input register lost a stalled byte");

endmodule

// ===== test/ubx_frame_deframer_core_test.sv =====
// ubx_frame_deframer_core_test: self-checking testbench for the UBX frame deframer.
// Depends on ufd_pkg and ubx_frame_deframer_core; predicts every result in-house.
`timescale 1ns / 1ps

module ubx_frame_deframer_core_test;

    import ufd_pkg::*;

    typedef logic [BYTE_W-1:0] byte_t;

    // Ways a generated frame can be broken
    typedef enum int {
        FAULT_NONE,
        FAULT_CK_A,
        FAULT_CK_B,
        FAULT_TRUNCATE
    } frame_fault_t;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_OFF_LONG = 80;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    byte_t                rx_byte   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 payload_valid;
    byte_t                payload_byte;
    logic [LEN_W-1:0]     payload_index;
    logic                 frame_done;
    logic                 checksum_ok;
    logic                 class_id_match;
    byte_t                frame_class;
    byte_t                frame_id;
    logic [LEN_W-1:0]     frame_length;
    logic [1:0]           start_status;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    byte_t                cfg_data  = '0;

    // Frame tracker state mirrored from the block, plus its registers
    logic [POS_W-1:0] trk_pos   = POS_SYNC1;
    byte_t            trk_class = '0;
    byte_t            trk_id    = '0;
    logic [LEN_W-1:0] trk_len   = '0;
    byte_t            fl_sum_a  = '0;
    byte_t            fl_sum_b  = '0;
    byte_t            rx_ck_a   = '0;
    byte_t            exp_class_reg = EXPECTED_CLASS_RST;
    byte_t            exp_id_reg    = EXPECTED_ID_RST;

    ufd_result_t pending_results[$];
    int          mismatch_count = 0;
    int unsigned framed_bytes   = 0;
    int          send_gap_pct   = 0;
    int          sink_stall_pct = 0;
    int          hold_off_left  = 0;

    ubx_frame_deframer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .payload_index  (payload_index),
        .frame_done     (frame_done),
        .checksum_ok    (checksum_ok),
        .class_id_match (class_id_match),
        .frame_class    (frame_class),
        .frame_id       (frame_id),
        .frame_length   (frame_length),
        .start_status   (start_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Fletcher-8 accumulation over class, id, length and payload
    function automatic void fletcher_add(input byte_t b);
        fl_sum_a = fl_sum_a + b;
        fl_sum_b = fl_sum_b + fl_sum_a;
    endfunction

    // Advance the frame tracker by one byte and queue the result it causes
    function automatic void track_byte(input byte_t b);
        ufd_result_t      r;
        logic [POS_W-1:0] off;
        r = '0;
        r.start_status = START_NONE;
        case (trk_pos)
            POS_SYNC1:
            begin
                if (b == SYNC_FIRST)
                    trk_pos = POS_SYNC2;
                else if (b == START_NMEA)
                    r.start_status = START_SEEN_NMEA;
                else if (b == START_RTCM)
                    r.start_status = START_SEEN_RTCM;
            end
            POS_SYNC2:
            begin
                if (b == SYNC_SECOND)
                begin
                    trk_pos   = POS_CLASS;
                    fl_sum_a  = '0;
                    fl_sum_b  = '0;
                    trk_class = '0;
                    trk_id    = '0;
                    trk_len   = '0;
                end
                else
                begin
                    r.start_status = START_BAD_SYNC;
                    trk_pos        = POS_SYNC1;
                end
            end
            POS_CLASS:
            begin
                trk_class = b;
                fletcher_add(b);
                trk_pos = POS_ID;
            end
            POS_ID:
            begin
                trk_id = b;
                fletcher_add(b);
                trk_pos = POS_LEN_LO;
            end
            POS_LEN_LO:
            begin
                trk_len = {8'h00, b};
                fletcher_add(b);
                trk_pos = POS_LEN_HI;
            end
            POS_LEN_HI:
            begin
                trk_len[15:8] = b;
                fletcher_add(b);
                trk_pos = POS_PAYLOAD;
            end
            default:
            begin
                off = trk_pos - POS_PAYLOAD;
                if (off < {1'b0, trk_len})
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = off[LEN_W-1:0];
                    fletcher_add(b);
                    trk_pos = trk_pos + POS_W'(1);
                end
                else if (off == {1'b0, trk_len})
                begin
                    rx_ck_a = b;
                    trk_pos = trk_pos + POS_W'(1);
                end
                else
                begin
                    r.frame_done     = 1'b1;
                    r.checksum_ok    = (rx_ck_a == fl_sum_a) && (b == fl_sum_b);
                    r.class_id_match = (trk_class == exp_class_reg) &&
                                       (trk_id == exp_id_reg);
                    trk_pos = POS_SYNC1;
                end
            end
        endcase
        r.frame_class  = trk_class;
        r.frame_id     = trk_id;
        r.frame_length = trk_len;
        pending_results.push_back(r);
    endfunction

    // Offer one byte, with a random gap first, and hold it until the transfer
    task automatic send_byte(input byte_t b);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_byte(b);
    endtask

    // Drop valid once the last byte of a burst is taken
    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    // Build a frame, break it as asked, and send it
    task automatic send_frame(input byte_t cls, input byte_t id,
                              input int unsigned len, input frame_fault_t fault);
        byte_t       seq[$];
        byte_t       ck_a;
        byte_t       ck_b;
        int unsigned stop_at;
        ck_a = '0;
        ck_b = '0;
        seq  = {SYNC_FIRST, SYNC_SECOND, cls, id, byte_t'(len), byte_t'(len >> 8)};
        for (int unsigned i = 0; i < len; i++)
            seq.push_back(byte_t'($urandom_range(0, 255)));
        for (int i = 2; i < seq.size(); i++)
        begin
            ck_a = ck_a + seq[i];
            ck_b = ck_b + ck_a;
        end
        if (fault == FAULT_CK_A)
            ck_a ^= byte_t'(1 << $urandom_range(0, 7));
        if (fault == FAULT_CK_B)
            ck_b ^= byte_t'(1 << $urandom_range(0, 7));
        seq.push_back(ck_a);
        seq.push_back(ck_b);
        stop_at = (fault == FAULT_TRUNCATE) ? $urandom_range(1, seq.size() - 1)
                                            : seq.size();
        for (int unsigned i = 0; i < stop_at; i++)
        begin
            send_byte(seq[i]);
            framed_bytes++;
        end
    endtask

    // Both configuration registers, written back to back
    task automatic set_expected(input byte_t cls, input byte_t id);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_CLASS;
        cfg_data  <= cls;
        @(posedge clk);
        cfg_index <= CFG_EXPECTED_ID;
        cfg_data  <= id;
        @(posedge clk);
        cfg_we <= 1'b0;
        exp_class_reg = cls;
        exp_id_reg    = id;
    endtask

    // Wait for all results, then let the two-stage pipeline drain
    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        ufd_result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t ns: result with none expected, expected nothing, got byte 0x%0h",
                     $time, payload_byte);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("payload_valid", 16'(want.payload_valid), 16'(payload_valid));
        compare_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
        compare_field("payload_index", want.payload_index, payload_index);
        compare_field("frame_done", 16'(want.frame_done), 16'(frame_done));
        compare_field("checksum_ok", 16'(want.checksum_ok), 16'(checksum_ok));
        compare_field("class_id_match", 16'(want.class_id_match), 16'(class_id_match));
        compare_field("frame_class", 16'(want.frame_class), 16'(frame_class));
        compare_field("frame_id", 16'(want.frame_id), 16'(frame_id));
        compare_field("frame_length", want.frame_length, frame_length);
        compare_field("start_status", 16'(want.start_status), 16'(start_status));
    endtask

    // Result side: check each transfer, then pick ready for the next cycle
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_result();
            if (hold_off_left > 0)
            begin
                out_ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("ubx_frame_deframer_core_test NOT OK");
        $finish;
    end

    // Idle-state bytes: strays, foreign starts, bad second sync
    task automatic test_idle_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_NMEA);
        send_byte(START_RTCM);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);   // bad second sync, not taken as a new first sync
        send_byte(SYNC_SECOND);  // stray while idle
        send_byte(SYNC_FIRST);
        send_byte(START_NMEA);   // bad second sync
    endtask

    // Zero-length frame at reset settings, then a one-byte frame with bad CK_B
    task automatic test_short_frames();
        send_frame(EXPECTED_CLASS_RST, EXPECTED_ID_RST, 0, FAULT_NONE);
        send_frame(8'hFF, 8'hFF, 1, FAULT_CK_B);
        end_burst();
    endtask

    // Class/id compare across register settings, extremes included
    task automatic test_class_id_match();
        wait_idle();
        set_expected(8'h00, 8'h00);
        send_frame(8'h00, 8'h00, 2, FAULT_NONE);
        send_frame(8'h00, 8'h01, 0, FAULT_NONE);
        send_frame(8'h06, 8'h00, 1, FAULT_CK_A);
        end_burst();
        wait_idle();
        set_expected(8'hFF, 8'hFF);
        send_frame(8'hFF, 8'hFF, 3, FAULT_NONE);
        send_frame(8'hFF, 8'h7F, 1, FAULT_NONE);
        send_frame(8'h7F, 8'hFF, 0, FAULT_NONE);
        end_burst();
    endtask

    task automatic random_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0: send_byte(START_NMEA);
                1: send_byte(START_RTCM);
                2:
                begin
                    send_byte(SYNC_FIRST);
                    send_byte(byte_t'($urandom_range(0, 255)));
                end
                default: send_byte(byte_t'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Mostly well-formed frames with random content, some broken, some noise
    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int unsigned n_items);
        int unsigned  stop_at;
        int unsigned  len;
        int           sel;
        byte_t        cls;
        byte_t        id;
        frame_fault_t fault;
        wait_idle();
        set_expected(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        stop_at = framed_bytes + n_items;
        while (framed_bytes < stop_at)
        begin
            sel = $urandom_range(0, 99);
            if (sel >= 88)
            begin
                random_noise();
            end
            else
            begin
                cls = byte_t'($urandom_range(0, 255));
                id  = byte_t'($urandom_range(0, 255));
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        cls = exp_class_reg;
                        id  = exp_id_reg;
                    end
                    2: cls = exp_class_reg;
                    default: ;
                endcase
                len = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 12)
                                                   : $urandom_range(13, 300);
                if (sel < 64)
                    fault = FAULT_NONE;
                else if (sel < 72)
                    fault = FAULT_CK_A;
                else if (sel < 80)
                    fault = FAULT_CK_B;
                else
                    fault = FAULT_TRUNCATE;
                send_frame(cls, id, len, fault);
            end
        end
        end_burst();
    endtask

    // Receiver holds off long enough that the block stalls its input
    task automatic test_backpressure();
        wait_idle();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        hold_off_left  = HOLD_OFF_LONG;
        send_frame(exp_class_reg, exp_id_reg, 40, FAULT_NONE);
        end_burst();
    endtask

    // Largest declared length; only the head of the payload is sent
    task automatic test_max_length();
        wait_idle();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(exp_class_reg);
        send_byte(exp_id_reg);
        send_byte(8'hFF);
        send_byte(8'hFF);
        repeat (24)
            send_byte(byte_t'($urandom_range(0, 255)));
        end_burst();
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_bytes();
        test_short_frames();
        test_class_id_match();
        test_random_traffic(0, 0, 130);
        test_random_traffic(46, 0, 130);
        test_random_traffic(0, 46, 130);
        test_random_traffic(23, 23, 130);
        test_backpressure();
        test_max_length();
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ubx_frame_deframer_core_test OK");
        else
            $display("ubx_frame_deframer_core_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ufd_pkg.sv
hw/rtl/ufd_parser.sv
hw/rtl/ubx_frame_deframer_core.sv
test/ubx_frame_deframer_core_test.sv
